### hw/rtl/rawl_pkg.sv
// Shared constants, codes and types of the register access whitelist.
package rawl_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int BUCKET_BITS = 6;

	localparam int ADDR_W  = 32;
	localparam int MASK_W  = 64;
	localparam int IDX_W   = 6;
	localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int COUNT_W = ENTRY_W + 1;
	localparam int CMP_W   = COUNT_W + IDX_W;

	localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
	localparam int BKT_W       = (BUCKET_BITS > 0) ? BUCKET_BITS : 1;

	// Multiplicative hash constant, split into 32-bit halves
	localparam logic [31:0] HASH_LO = 32'h80B583EB;
	localparam logic [31:0] HASH_HI = 32'h61C88646;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [MASK_W-1:0] mask;
		logic [IDX_W-1:0]  idx;
		logic [BKT_W-1:0]  bucket;
	} cmd_t;

endpackage

### hw/rtl/rawl_front.sv
// Front end: takes commands and works out the hash bucket of each address.
module rawl_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic [rawl_pkg::ADDR_W-1:0]  reg_address,
	input  logic [rawl_pkg::MASK_W-1:0]  mask_in,
	input  logic [rawl_pkg::IDX_W-1:0]   entry_index,
	input  logic                         q_full,
	output logic                         q_push,
	output rawl_pkg::cmd_t               q_cmd
);
	import rawl_pkg::*;

	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [MASK_W-1:0] mask_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [63:0]       prod_lo_s1;
	logic [31:0]       prod_hi_s1;
	logic [31:0]       hash_hi;
	logic              accept;

	assign accept   = in_valid && in_ready;
	assign q_push   = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Only the upper half of the 64-bit product matters, so the high
	// multiplier half needs just its low 32 result bits.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= opcode;
			addr_s1    <= reg_address;
			mask_s1    <= mask_in;
			idx_s1     <= entry_index;
			prod_lo_s1 <= {32'd0, reg_address} * {32'd0, HASH_LO};
			prod_hi_s1 <= reg_address * HASH_HI;
		end
	end

	assign hash_hi = prod_lo_s1[63:32] + prod_hi_s1;

	always_comb begin
		q_cmd.op   = op_s1;
		q_cmd.addr = addr_s1;
		q_cmd.mask = mask_s1;
		q_cmd.idx  = idx_s1;
		if (BUCKET_BITS == 0) begin
			q_cmd.bucket = '0;
		end else begin
			q_cmd.bucket = BKT_W'(hash_hi >> (32 - BUCKET_BITS));
		end
	end

endmodule

### hw/rtl/rawl_fifo.sv
// Short command queue between the front end and the table engine.
module rawl_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rawl_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           pop,
	output rawl_pkg::cmd_t rd_data,
	output logic           empty
);
	import rawl_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	assign full    = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### hw/rtl/rawl_back.sv
// Table engine: bucket chain walk, inserts, clears and indexed reads.
module rawl_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  rawl_pkg::cmd_t                q_cmd,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [rawl_pkg::MASK_W-1:0]   mask_out,
	output logic [rawl_pkg::ADDR_W-1:0]   address_out,
	output logic [1:0]                    status,
	output logic [rawl_pkg::COUNT_W-1:0]  entry_count
);
	import rawl_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HEAD = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_READ = 2'd3;

	logic [1:0]             state_q, state_d;
	cmd_t                   cmd_q;
	logic [COUNT_W-1:0]     count_q;
	logic [NUM_BUCKETS-1:0] head_valid_q;

	logic [ENTRY_W-1:0] head_mem [NUM_BUCKETS];
	logic [ADDR_W-1:0]  key_mem  [MAX_ENTRIES];
	logic [MASK_W-1:0]  mask_mem [MAX_ENTRIES];
	logic [ENTRY_W:0]   link_mem [MAX_ENTRIES];   // top bit marks chain end

	logic [ENTRY_W-1:0] head_rd_q;
	logic               head_hit_q;
	logic [ADDR_W-1:0]  key_rd_q;
	logic [MASK_W-1:0]  mask_rd_q;
	logic [ENTRY_W:0]   link_rd_q;

	logic               head_rd_en;
	logic               ent_rd_en;
	logic [ENTRY_W-1:0] ent_rd_addr;
	logic               resolve;
	logic               hit;
	logic               tbl_wr_en;
	logic               tbl_clr;
	logic               idx_ok;

	logic               res_en;
	logic               res_found;
	logic [MASK_W-1:0]  res_mask;
	logic [ADDR_W-1:0]  res_addr;
	logic [1:0]         res_status;

	logic               out_valid_q;
	logic               found_q;
	logic [MASK_W-1:0]  mask_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [1:0]         status_q;

	assign idx_ok = CMP_W'(q_cmd.idx) < CMP_W'(count_q);

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		head_rd_en  = 1'b0;
		ent_rd_en   = 1'b0;
		ent_rd_addr = head_rd_q;
		resolve     = 1'b0;
		hit         = 1'b0;
		tbl_wr_en   = 1'b0;
		tbl_clr     = 1'b0;
		res_en      = 1'b0;
		res_found   = 1'b0;
		res_mask    = '0;
		res_addr    = '0;
		res_status  = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				// take a new command only once the last result has gone
				if (!q_empty && !out_valid_q) begin
					q_pop = 1'b1;
					unique case (q_cmd.op) inside
						OP_LOOKUP, OP_INSERT: begin
							head_rd_en = 1'b1;
							state_d    = S_HEAD;
						end
						OP_CLEAR: begin
							tbl_clr = 1'b1;
							res_en  = 1'b1;
						end
						default: begin
							if (idx_ok) begin
								ent_rd_en   = 1'b1;
								ent_rd_addr = ENTRY_W'(q_cmd.idx);
								state_d     = S_READ;
							end else begin
								res_en     = 1'b1;
								res_status = ST_RANGE;
							end
						end
					endcase
				end
			end
			S_HEAD: begin
				if (head_hit_q && (COUNT_W'(head_rd_q) < count_q)) begin
					ent_rd_en   = 1'b1;
					ent_rd_addr = head_rd_q;
					state_d     = S_WALK;
				end else begin
					resolve = 1'b1;
				end
			end
			S_WALK: begin
				if (key_rd_q == cmd_q.addr) begin
					resolve = 1'b1;
					hit     = 1'b1;
				end else if (!link_rd_q[ENTRY_W] &&
				             (COUNT_W'(link_rd_q[ENTRY_W-1:0]) < count_q)) begin
					// follow the chain
					ent_rd_en   = 1'b1;
					ent_rd_addr = link_rd_q[ENTRY_W-1:0];
				end else begin
					resolve = 1'b1;
				end
			end
			S_READ: begin
				res_en    = 1'b1;
				res_found = 1'b1;
				res_mask  = mask_rd_q;
				res_addr  = key_rd_q;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (resolve) begin
			state_d = S_IDLE;
			res_en  = 1'b1;
			if (cmd_q.op == OP_LOOKUP) begin
				res_found = hit;
				res_mask  = hit ? mask_rd_q : '0;
			end else if (hit) begin
				// duplicate address drops the whole table
				tbl_clr    = 1'b1;
				res_status = ST_DUP;
			end else if (count_q == COUNT_W'(MAX_ENTRIES)) begin
				res_status = ST_FULL;
			end else begin
				tbl_wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			head_valid_q <= '0;
			head_hit_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tbl_clr) begin
				head_valid_q <= '0;
				count_q      <= '0;
			end else if (tbl_wr_en) begin
				head_valid_q[cmd_q.bucket] <= 1'b1;
				count_q                    <= count_q + 1'b1;
			end
			if (head_rd_en) begin
				head_hit_q <= head_valid_q[q_cmd.bucket];
			end
			if (res_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (res_en) begin
			found_q  <= res_found;
			mask_q   <= res_mask;
			addr_q   <= res_addr;
			status_q <= res_status;
		end
	end

	// Bucket heads: new entry goes to the front of its chain
	always_ff @(posedge clk) begin
		if (head_rd_en) begin
			head_rd_q <= head_mem[q_cmd.bucket];
		end
		if (tbl_wr_en) begin
			head_mem[cmd_q.bucket] <= count_q[ENTRY_W-1:0];
		end
	end

	// Entry stores, appended in insertion order
	always_ff @(posedge clk) begin
		if (ent_rd_en) begin
			key_rd_q  <= key_mem[ent_rd_addr];
			mask_rd_q <= mask_mem[ent_rd_addr];
			link_rd_q <= link_mem[ent_rd_addr];
		end
		if (tbl_wr_en) begin
			key_mem[count_q[ENTRY_W-1:0]]  <= cmd_q.addr;
			mask_mem[count_q[ENTRY_W-1:0]] <= cmd_q.mask;
			link_mem[count_q[ENTRY_W-1:0]] <= {!head_hit_q, head_rd_q};
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign mask_out    = mask_q;
	assign address_out = addr_q;
	assign status      = status_q;
	assign entry_count = count_q;

endmodule

### hw/rtl/register_access_whitelist_core.sv
// Top level of the register access whitelist: front end, queue and table engine.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------------
//  in      | into core | in_valid/in_ready   | opcode, reg_address, mask_in, entry_index
//  out     | from core | out_valid/out_ready | found, mask_out, address_out, status
//
// The front end registers the hash multiply of each command, then queues it.
// The engine answers a clear or an out-of-range read straight from idle, a read by
// index after one registered entry read, and a lookup or insert after reading the
// bucket head and then one registered memory read per chain entry visited; a miss on
// an empty bucket ends at the head read.
// Reset empties the table at once through per-bucket valid bits; no clearing pass.
// A stalled result holds the engine; up to three commands more wait in front of it.
module register_access_whitelist_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic [rawl_pkg::ADDR_W-1:0]  reg_address,
	input  logic [rawl_pkg::MASK_W-1:0]  mask_in,
	input  logic [rawl_pkg::IDX_W-1:0]   entry_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [rawl_pkg::MASK_W-1:0]  mask_out,
	output logic [rawl_pkg::ADDR_W-1:0]  address_out,
	output logic [1:0]                   status
);
	import rawl_pkg::*;

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	cmd_t               q_wr_cmd;
	cmd_t               q_rd_cmd;
	logic [COUNT_W-1:0] entry_count;

	rawl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.reg_address (reg_address),
		.mask_in     (mask_in),
		.entry_index (entry_index),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_wr_cmd)
	);

	rawl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_rd_cmd),
		.empty   (q_empty)
	);

	rawl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (q_rd_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.mask_out    (mask_out),
		.address_out (address_out),
		.status      (status),
		.entry_count (entry_count)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= COUNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("transfer into full command queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command taken from empty queue");

	a_pop_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !out_valid)
		else $error("command started while a result is pending");

endmodule
